/* rtl/lpg_pkg.sv */
// types and constants shared by the line pixel generator modules
// no dependencies
`default_nettype none

package lpg_pkg;

  localparam int COORD_BITS = 12;
  localparam int DELTA_BITS = 13;
  localparam int ERR_BITS   = 14;
  localparam int ROW_BITS   = 10;
  localparam int COLOR_BITS = 8;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  typedef struct packed {
    logic                          cmd;
    logic signed [COORD_BITS-1:0]  start_x;
    logic signed [COORD_BITS-1:0]  start_y;
    logic signed [COORD_BITS-1:0]  end_x;
    logic signed [COORD_BITS-1:0]  end_y;
    logic [COLOR_BITS-1:0]         color_red;
    logic [COLOR_BITS-1:0]         color_green;
    logic [COLOR_BITS-1:0]         color_blue;
  } lpg_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0]  pix_x;
    logic signed [COORD_BITS-1:0]  pix_y;
    logic [ROW_BITS-1:0]           frame_row;
    logic                          on_screen;
    logic [COLOR_BITS-1:0]         out_red;
    logic [COLOR_BITS-1:0]         out_green;
    logic [COLOR_BITS-1:0]         out_blue;
    logic                          last;
  } lpg_out_t;

  // decoded command with line setup already worked out
  typedef struct packed {
    logic                          is_load;
    logic signed [COORD_BITS-1:0]  cur_x;
    logic signed [COORD_BITS-1:0]  cur_y;
    logic signed [COORD_BITS-1:0]  goal_x;
    logic signed [COORD_BITS-1:0]  goal_y;
    logic [DELTA_BITS-1:0]         delta_x;
    logic signed [DELTA_BITS-1:0]  neg_delta_y;
    logic                          step_x_neg;
    logic                          step_y_neg;
    logic signed [ERR_BITS-1:0]    error_term;
    logic [3*COLOR_BITS-1:0]       line_color;
  } lpg_op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lpg_q_stat_t;

  typedef struct packed {
    logic busy;
    logic pop;
    logic emit;
  } lpg_back_stat_t;

endpackage

`default_nettype wire

/* rtl/line_pixel_generator_unit.sv */
// line pixel generator: Bresenham stepping with frame clipping
// flow: a command is written into the queue at its transfer and popped once the
//   output stage can take it; an advance popped while a line runs registers its pixel
// throughput: one command per cycle (single-step back end) unless output stalls
// reset: synchronous, clears the queue, the busy flag and the output valid
// depends on lpg_pkg, lpg_front, lpg_queue, lpg_back
`default_nettype none

module line_pixel_generator_unit #(
  parameter int FRAME_WIDTH  = 800,
  parameter int FRAME_HEIGHT = 600
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire lpg_pkg::lpg_in_t in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output lpg_pkg::lpg_out_t  out_data
);

  lpg_pkg::lpg_op_t        dec_op;
  lpg_pkg::lpg_op_t        head_op;
  lpg_pkg::lpg_q_stat_t    q_stat;
  lpg_pkg::lpg_back_stat_t b_stat;

  lpg_front u_front (
    .in_item (in_data),
    .op      (dec_op)
  );

  lpg_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_valid),
    .push_op (dec_op),
    .pop     (b_stat.pop),
    .head_op (head_op),
    .stat    (q_stat)
  );

  lpg_back #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_stat.empty),
    .head_op   (head_op),
    .stat      (b_stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign in_ready = !q_stat.full;

  a_q_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_rise_needs_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(b_stat.emit))
    else $error("pixel appeared without a step");

  a_busy_ends_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(b_stat.busy) && $past(rst_n)) |-> (out_valid && out_data.last))
    else $error("line ended without a last pixel");

  a_emit_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    b_stat.emit |-> (b_stat.busy && b_stat.pop))
    else $error("pixel stepped while idle");

endmodule

`default_nettype wire

/* rtl/lpg_front.sv */
// front end: decodes a command and works out the line setup on load
// depends on lpg_pkg
`default_nettype none

module lpg_front (
  input  wire lpg_pkg::lpg_in_t in_item,
  output lpg_pkg::lpg_op_t      op
);

  logic signed [lpg_pkg::DELTA_BITS-1:0] diff_x;
  logic signed [lpg_pkg::DELTA_BITS-1:0] diff_y;
  logic [lpg_pkg::DELTA_BITS-1:0]        abs_x;
  logic signed [lpg_pkg::DELTA_BITS-1:0] nabs_y;

  always_comb begin
    diff_x = lpg_pkg::DELTA_BITS'(in_item.end_x) - lpg_pkg::DELTA_BITS'(in_item.start_x);
    diff_y = lpg_pkg::DELTA_BITS'(in_item.end_y) - lpg_pkg::DELTA_BITS'(in_item.start_y);
    abs_x  = diff_x[lpg_pkg::DELTA_BITS-1] ? $unsigned(-diff_x) : $unsigned(diff_x);
    nabs_y = diff_y[lpg_pkg::DELTA_BITS-1] ? diff_y : -diff_y;

    op.is_load     = (in_item.cmd == lpg_pkg::CMD_LOAD);
    op.cur_x       = in_item.start_x;
    op.cur_y       = in_item.start_y;
    op.goal_x      = in_item.end_x;
    op.goal_y      = in_item.end_y;
    op.delta_x     = abs_x;
    op.neg_delta_y = nabs_y;
    // equal coordinates count as a negative step
    op.step_x_neg  = !(in_item.start_x < in_item.end_x);
    op.step_y_neg  = !(in_item.start_y < in_item.end_y);
    op.error_term  = $signed({1'b0, abs_x}) + lpg_pkg::ERR_BITS'(nabs_y);
    op.line_color  = {in_item.color_red, in_item.color_green, in_item.color_blue};
  end

endmodule

`default_nettype wire

/* rtl/lpg_queue.sv */
// two-entry queue between the command front end and the stepping back end
// depends on lpg_pkg
`default_nettype none

module lpg_queue (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    push,
  input  wire lpg_pkg::lpg_op_t  push_op,
  input  wire                    pop,
  output lpg_pkg::lpg_op_t       head_op,
  output lpg_pkg::lpg_q_stat_t   stat
);

  lpg_pkg::lpg_op_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  always_comb begin
    stat.full  = (count_r == 2'd2);
    stat.empty = (count_r == 2'd0);
    do_push    = push && !stat.full;
    do_pop     = pop && !stat.empty;
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
    head_op    = entry_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

`default_nettype wire

/* rtl/lpg_back.sv */
// back end: holds the running line, steps it one pixel per advance and
// registers the pixel for the output channel; depends on lpg_pkg
`default_nettype none

module lpg_back #(
  parameter int FRAME_WIDTH  = 800,
  parameter int FRAME_HEIGHT = 600
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      q_empty,
  input  wire lpg_pkg::lpg_op_t    head_op,
  output lpg_pkg::lpg_back_stat_t  stat,
  output logic                     out_valid,
  input  wire                      out_ready,
  output lpg_pkg::lpg_out_t        out_data
);

  localparam int CB = lpg_pkg::COORD_BITS;
  localparam int EB = lpg_pkg::ERR_BITS;
  localparam logic [CB-1:0] FW_U   = CB'(FRAME_WIDTH);
  localparam logic [CB-1:0] FH_U   = CB'(FRAME_HEIGHT);
  localparam logic [CB-1:0] FH_M1  = CB'(FRAME_HEIGHT - 1);

  logic                          busy_r, busy_nxt;
  logic                          out_valid_r, out_valid_nxt;
  lpg_pkg::lpg_op_t              line_r, line_nxt;
  lpg_pkg::lpg_out_t             pix_r, pix_nxt;

  logic                          take;
  logic                          emit;
  logic                          vis;
  logic                          fin;
  logic [CB-1:0]                 row_full;
  logic signed [EB:0]            e2;
  logic                          move_x, move_y;
  logic signed [EB:0]            err_sum;

  always_comb begin
    // the output stage can take a pixel when empty or being drained
    take = !q_empty && (!out_valid_r || out_ready);
    emit = take && !head_op.is_load && busy_r;

    vis = !line_r.cur_x[CB-1] && ($unsigned(line_r.cur_x) < FW_U) &&
          !line_r.cur_y[CB-1] && ($unsigned(line_r.cur_y) < FH_U);
    fin = (line_r.cur_x == line_r.goal_x) && (line_r.cur_y == line_r.goal_y);
    row_full = FH_M1 - $unsigned(line_r.cur_y);

    e2     = {line_r.error_term, 1'b0};
    move_x = (e2 >= (EB+1)'(line_r.neg_delta_y));
    move_y = (e2 <= $signed((EB+1)'(line_r.delta_x)));
    err_sum = (EB+1)'(line_r.error_term)
            + (move_x ? (EB+1)'(line_r.neg_delta_y) : '0)
            + (move_y ? $signed((EB+1)'(line_r.delta_x)) : '0);

    pix_nxt.pix_x     = line_r.cur_x;
    pix_nxt.pix_y     = line_r.cur_y;
    pix_nxt.frame_row = vis ? row_full[lpg_pkg::ROW_BITS-1:0] : '0;
    pix_nxt.on_screen = vis;
    pix_nxt.out_red   = line_r.line_color[23:16];
    pix_nxt.out_green = line_r.line_color[15:8];
    pix_nxt.out_blue  = line_r.line_color[7:0];
    pix_nxt.last      = fin;

    line_nxt = line_r;
    busy_nxt = busy_r;
    if (take && head_op.is_load) begin
      line_nxt = head_op;
      busy_nxt = 1'b1;
    end else if (emit) begin
      if (fin) begin
        busy_nxt = 1'b0;
      end else begin
        line_nxt.error_term = err_sum[EB-1:0];
        if (move_x) begin
          line_nxt.cur_x = line_r.step_x_neg ? line_r.cur_x - CB'(1) : line_r.cur_x + CB'(1);
        end
        if (move_y) begin
          line_nxt.cur_y = line_r.step_y_neg ? line_r.cur_y - CB'(1) : line_r.cur_y + CB'(1);
        end
      end
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end

    stat.busy = busy_r;
    stat.pop  = take;
    stat.emit = emit;
    out_valid = out_valid_r;
    out_data  = pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    line_r <= line_nxt;
    if (emit) begin
      pix_r <= pix_nxt;
    end
  end

endmodule

`default_nettype wire

/* tb/sv/lpg_pixel_checker.sv */
`timescale 1ns / 1ps
// pixel checker for line_pixel_generator_unit: follows both channels, steps its own
// line rasterizer on each input transfer and compares every output transfer
// depends on lpg_pkg
module lpg_pixel_checker #(
  parameter int FRAME_WIDTH  = 800,
  parameter int FRAME_HEIGHT = 600
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  lpg_pkg::lpg_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  lpg_pkg::lpg_out_t out_data,
  output int                fail_count,
  output int                pending_count
);
  import lpg_pkg::*;

  // line state as the block keeps it
  logic signed [COORD_BITS-1:0] pos_x, pos_y, goal_x, goal_y;
  logic [DELTA_BITS-1:0]        span_x;
  logic signed [DELTA_BITS-1:0] neg_span_y;
  logic                         x_down, y_down;
  logic signed [ERR_BITS-1:0]   err_acc;
  logic [3*COLOR_BITS-1:0]      line_rgb;
  logic                         drawing;

  lpg_out_t expected_pixels[$];

  task automatic clear_line();
    pos_x = '0; pos_y = '0; goal_x = '0; goal_y = '0;
    span_x = '0; neg_span_y = '0; x_down = 1'b0; y_down = 1'b0;
    err_acc = '0; line_rgb = '0; drawing = 1'b0;
  endtask

  task automatic step_line(input lpg_in_t item);
    int sx, sy, ex, ey, cx, cy, err, e2, dx, dy;
    logic vis, at_end;
    lpg_out_t px;
    if (item.cmd == CMD_LOAD) begin
      sx = $signed(item.start_x);
      sy = $signed(item.start_y);
      ex = $signed(item.end_x);
      ey = $signed(item.end_y);
      dx = (ex > sx) ? ex - sx : sx - ex;
      dy = (ey > sy) ? ey - sy : sy - ey;
      pos_x = sx[COORD_BITS-1:0];
      pos_y = sy[COORD_BITS-1:0];
      goal_x = ex[COORD_BITS-1:0];
      goal_y = ey[COORD_BITS-1:0];
      span_x = dx[DELTA_BITS-1:0];
      neg_span_y = DELTA_BITS'(-dy);
      // equal coordinates count as a negative step
      x_down = !(sx < ex);
      y_down = !(sy < ey);
      err = dx - dy;
      err_acc = err[ERR_BITS-1:0];
      line_rgb = {item.color_red, item.color_green, item.color_blue};
      drawing = 1'b1;
    end else if (drawing) begin
      cx = $signed(pos_x);
      cy = $signed(pos_y);
      vis = cx >= 0 && cx < FRAME_WIDTH && cy >= 0 && cy < FRAME_HEIGHT;
      at_end = (pos_x == goal_x) && (pos_y == goal_y);
      px.pix_x = pos_x;
      px.pix_y = pos_y;
      px.frame_row = vis ? ROW_BITS'(FRAME_HEIGHT - cy - 1) : '0;
      px.on_screen = vis;
      {px.out_red, px.out_green, px.out_blue} = line_rgb;
      px.last = at_end;
      expected_pixels.push_back(px);
      if (at_end) begin
        drawing = 1'b0;
      end else begin
        err = $signed(err_acc);
        e2 = 2 * err;
        if (e2 >= int'($signed(neg_span_y))) begin
          err = err + $signed(neg_span_y);
          cx = x_down ? cx - 1 : cx + 1;
        end
        if (e2 <= int'(span_x)) begin
          err = err + int'(span_x);
          cy = y_down ? cy - 1 : cy + 1;
        end
        err_acc = err[ERR_BITS-1:0];
        pos_x = cx[COORD_BITS-1:0];
        pos_y = cy[COORD_BITS-1:0];
      end
    end
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_pixel(input lpg_out_t got);
    lpg_out_t want;
    if (expected_pixels.size() == 0) begin
      $error("pixel transfer with none expected: x %0d y %0d",
             $signed(got.pix_x), $signed(got.pix_y));
      fail_count++;
    end else begin
      want = expected_pixels.pop_front();
      check_field("pix_x", $signed(want.pix_x), $signed(got.pix_x));
      check_field("pix_y", $signed(want.pix_y), $signed(got.pix_y));
      check_field("frame_row", want.frame_row, got.frame_row);
      check_field("on_screen", want.on_screen, got.on_screen);
      check_field("out_red", want.out_red, got.out_red);
      check_field("out_green", want.out_green, got.out_green);
      check_field("out_blue", want.out_blue, got.out_blue);
      check_field("last", want.last, got.last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_line();
      expected_pixels.delete();
      fail_count = 0;
    end else begin
      // an output transfer always belongs to an earlier input transfer
      if (out_valid && out_ready) check_pixel(out_data);
      if (in_valid && in_ready) step_line(in_data);
    end
    pending_count = expected_pixels.size();
  end

endmodule

/* tb/sv/tb_line_pixel_generator_unit.sv */
`timescale 1ns / 1ps
// testbench top for line_pixel_generator_unit: clock, reset, load and advance
// traffic, output stalls and the verdict; depends on lpg_pkg and lpg_pixel_checker
module tb_line_pixel_generator_unit;
  import lpg_pkg::*;

  localparam int FRAME_W    = 800;
  localparam int FRAME_H    = 600;
  localparam int ITEM_TOTAL = 1325;
  localparam int COORD_MIN  = -(1 << (COORD_BITS - 1));
  localparam int COORD_MAX  = (1 << (COORD_BITS - 1)) - 1;

  logic     clk, rst_n;
  logic     in_valid, in_ready, out_valid, out_ready;
  lpg_in_t  in_data;
  lpg_out_t out_data;
  int       fail_count, pending_count;
  int       sent;
  bit       in_gaps, out_gaps;

  line_pixel_generator_unit #(
    .FRAME_WIDTH (FRAME_W),
    .FRAME_HEIGHT(FRAME_H)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  lpg_pixel_checker #(
    .FRAME_WIDTH (FRAME_W),
    .FRAME_HEIGHT(FRAME_H)
  ) u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_line_pixel_generator_unit: FAIL");
    $finish;
  end

  always @(negedge clk) begin
    out_ready = !(out_gaps && $urandom_range(99) < 8);
  end

  task automatic send_item(input lpg_in_t item);
    @(negedge clk);
    while (in_gaps && $urandom_range(99) < 8) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_data = item;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic send_load(input int sx, input int sy, input int ex, input int ey,
                           input logic [23:0] rgb);
    lpg_in_t item;
    item.cmd = CMD_LOAD;
    item.start_x = sx[COORD_BITS-1:0];
    item.start_y = sy[COORD_BITS-1:0];
    item.end_x = ex[COORD_BITS-1:0];
    item.end_y = ey[COORD_BITS-1:0];
    {item.color_red, item.color_green, item.color_blue} = rgb;
    send_item(item);
  endtask

  function automatic lpg_in_t noise_item();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return bits[$bits(lpg_in_t)-1:0];
  endfunction

  // payload of an advance is ignored, so it carries noise
  task automatic send_advances(input int n);
    lpg_in_t item;
    repeat (n) begin
      item = noise_item();
      item.cmd = CMD_ADVANCE;
      send_item(item);
    end
  endtask

  // lower valid and hold off until every expected pixel has come
  task automatic hold_until_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  function automatic int clamp_coord(input int v);
    if (v < COORD_MIN) return COORD_MIN;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  function automatic int near_frame(input int size);
    return int'($urandom_range(size + 60)) - 30;
  endfunction

  // one line: a load, then mostly its full run of advances, sometimes cut short
  // by the next load or followed by advances while idle
  task automatic random_line();
    int sx, sy, ex, ey, dx, dy, reach, len, pick, n;
    lpg_in_t item;
    pick = $urandom_range(99);
    if (pick < 3) begin
      item = noise_item();
      item.cmd = CMD_LOAD;
      sx = $signed(item.start_x);
      sy = $signed(item.start_y);
      ex = $signed(item.end_x);
      ey = $signed(item.end_y);
      send_item(item);
    end else begin
      if ($urandom_range(1)) begin
        sx = near_frame(FRAME_W);
        sy = near_frame(FRAME_H);
      end else begin
        sx = int'($urandom_range(COORD_MAX - COORD_MIN)) + COORD_MIN;
        sy = int'($urandom_range(COORD_MAX - COORD_MIN)) + COORD_MIN;
      end
      reach = ($urandom_range(9) == 0) ? 60 : 12;
      dx = int'($urandom_range(2 * reach)) - reach;
      dy = int'($urandom_range(2 * reach)) - reach;
      case (pick % 4)
        0: dy = 0;
        1: dx = 0;
        2: dy = $urandom_range(1) ? dx : -dx;
        default: ;
      endcase
      ex = clamp_coord(sx + dx);
      ey = clamp_coord(sy + dy);
      send_load(sx, sy, ex, ey, 24'($urandom_range(24'hFF_FFFF)));
    end
    dx = (ex > sx) ? ex - sx : sx - ex;
    dy = (ey > sy) ? ey - sy : sy - ey;
    len = ((dx > dy) ? dx : dy) + 1;
    // very long random lines are cut short by the next load
    if (len > 64) len = 64;
    pick = $urandom_range(9);
    if (pick == 0) n = $urandom_range(len - 1);
    else if (pick == 1) n = len + $urandom_range(3, 1);
    else n = len;
    send_advances(n);
  endtask

  initial begin
    lpg_in_t item;
    bit drained;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    in_gaps = 1'b1;
    out_gaps = 1'b1;
    sent = 0;
    drained = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // advance while idle, then a single point line
    send_advances(1);
    send_load(0, 0, 0, 0, 24'hFF_FFFF);
    send_advances(1);
    // across the bottom right frame corner
    send_load(FRAME_W - 1, FRAME_H - 1, FRAME_W, FRAME_H, 24'h00_0000);
    send_advances(2);
    // across the left edge
    send_load(-1, 1, 1, 1, 24'hA5_5A_C3);
    send_advances(3);
    // coordinate extremes
    send_load(COORD_MAX, COORD_MIN, COORD_MAX - 2, COORD_MIN, 24'h5A_A5_3C);
    send_advances(3);
    send_load(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX - 2, 24'h12_34_56);
    send_advances(3);
    // load during a line, then advance past the end
    send_load(5, 5, 15, 9, 24'h80_01_7F);
    send_advances(2);
    send_load(3, 0, 3, 0, 24'h01_80_FE);
    send_advances(2);

    while (sent < ITEM_TOTAL) begin
      in_gaps = !(sent >= 500 && sent < 800);
      out_gaps = in_gaps;
      if (!drained && sent >= 900) begin
        hold_until_drained();
        drained = 1'b1;
      end
      if ($urandom_range(19) == 0) begin
        item = noise_item();
        send_item(item);
      end else begin
        random_line();
      end
    end

    hold_until_drained();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_line_pixel_generator_unit: PASS");
    end else begin
      $display("tb_line_pixel_generator_unit: FAIL");
    end
    $finish;
  end

endmodule

/* line_pixel_generator_unit.f */
rtl/lpg_pkg.sv
rtl/lpg_front.sv
rtl/lpg_queue.sv
rtl/lpg_back.sv
rtl/line_pixel_generator_unit.sv
tb/sv/lpg_pixel_checker.sv
tb/sv/tb_line_pixel_generator_unit.sv
